### rtl/s83f_pkg.sv
// ----------------------------------------------------------------------------
// s83f_pkg
// Shared widths, character codes, register indexes and the helper functions
// of the 8.3 short-name filter.
// ----------------------------------------------------------------------------
package s83f_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned BASE_LEN   = 8;
   localparam int unsigned EXT_LEN    = 3;
   localparam int unsigned BASE_W     = BASE_LEN * BYTE_W;
   localparam int unsigned EXT_W      = EXT_LEN * BYTE_W;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;

   // register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BASE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_EXT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_EVERYTHING = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'h20;

   function automatic logic [7:0] upcase(logic [7:0] c);
      return (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - CASE_DIFF : c;
   endfunction

   // control bytes, space, DEL and above, and reserved punctuation
   function automatic logic forbidden(logic [7:0] c);
      logic bad;
      bad = (c <= CHAR_SPACE) || (c >= CHAR_DEL);
      case (c) inside
         8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C,
         8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C: bad = 1'b1;
         default: ;
      endcase
      return bad;
   endfunction

   // Wildcard compare of one field, lane by lane. Pattern and name positions
   // stay in step: '?' past the end of the name lands on a zero name byte.
   // The first deciding lane wins; '*' or a joint end decide success.
   function automatic logic field_match(logic [BASE_W-1:0] pat, logic [BASE_W-1:0] nm);
      logic       done;
      logic       ok;
      logic [7:0] p;
      logic [7:0] ch;
      done = 1'b0;
      ok   = 1'b1;
      for (int i = 0; i < BASE_LEN; i++) begin
         p  = pat[BYTE_W*i +: BYTE_W];
         ch = nm[BYTE_W*i +: BYTE_W];
         if (!done) begin
            if (p == CHAR_STAR || (p == CHAR_NUL && ch == CHAR_NUL)) begin
               done = 1'b1;
            end else if (p != CHAR_QMARK && upcase(p) != upcase(ch)) begin
               done = 1'b1;
               ok   = 1'b0;
            end
         end
      end
      return ok;
   endfunction

endpackage

### rtl/s83f_if.sv
// ----------------------------------------------------------------------------
// s83f channel interfaces
// Name byte, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface s83f_req_if;
   logic                          valid;
   logic                          ready;
   logic [s83f_pkg::BYTE_W-1:0]   name_byte;
   logic                          final_byte;

   modport source (output valid, output name_byte, output final_byte, input ready);
   modport sink   (input valid, input name_byte, input final_byte, output ready);
endinterface

interface s83f_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          fits_short_form;
   logic                          pattern_hit;
   logic [s83f_pkg::BASE_W-1:0]   short_base;
   logic [s83f_pkg::EXT_W-1:0]    short_ext;
   logic                          had_dot;

   modport source (output valid, output fits_short_form, output pattern_hit,
                   output short_base, output short_ext, output had_dot, input ready);
   modport sink   (input valid, input fits_short_form, input pattern_hit,
                   input short_base, input short_ext, input had_dot, output ready);
endinterface

interface s83f_csr_if;
   logic                              valid;
   logic                              ready;
   logic [s83f_pkg::CSR_IDX_W-1:0]    reg_index;
   logic [s83f_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/short_name_83_filter_core.sv
// ----------------------------------------------------------------------------
// short_name_83_filter_core
// Streaming 8.3 short-name check with case-blind wildcard match.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries a host file name one byte per transaction; final_byte
//    marks its last byte. Only the final byte produces a transaction on
//    rsp_if, carrying the legality flag, the upper-cased short form, the dot
//    flag and the pattern hit.
//  - csr_if writes the pattern registers (index 0 base, 1 extension,
//    2 match-everything). It is always ready; write only while idle.
//  - Throughput: one name byte per cycle while no final byte waits on rsp_if,
//    set by the single processing stage between input and result register.
//  - The final byte is first held in the input register and then loads the
//    result register once it is free; rsp_if.valid rises with that load.
//  - When rsp_if stalls, non-final bytes keep flowing into the name state;
//    a final byte waits in the input register until the result register
//    frees, so req_if.ready then drops.
//  - Reset clears the name state and the valid flags of both stage registers,
//    and restores the pattern to "*" with match-everything set.
// ----------------------------------------------------------------------------
module short_name_83_filter_core (
   input  logic        clock,
   input  logic        reset,
   s83f_req_if.sink    req_if,
   s83f_rsp_if.source  rsp_if,
   s83f_csr_if.sink    csr_if
);

   localparam int unsigned BW = s83f_pkg::BYTE_W;

   // configuration
   logic [s83f_pkg::BASE_W-1:0] pat_base_ff;
   logic [s83f_pkg::EXT_W-1:0]  pat_ext_ff;
   logic                        match_all_ff;

   // input register
   logic          hold_valid_ff, hold_valid_in;
   logic [BW-1:0] hold_byte_ff, hold_byte_in;
   logic          hold_final_ff, hold_final_in;

   // name state
   logic [s83f_pkg::BASE_W-1:0] base_store_ff, base_store_in;
   logic [s83f_pkg::EXT_W-1:0]  ext_store_ff, ext_store_in;
   logic [3:0]                  base_count_ff, base_count_in;
   logic [2:0]                  ext_count_ff, ext_count_in;
   logic [1:0]                  dot_count_ff, dot_count_in;
   logic                        bad_seen_ff, bad_seen_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        fits_ff, fits_in;
   logic                        hit_ff, hit_in;
   logic [s83f_pkg::BASE_W-1:0] short_base_ff, short_base_in;
   logic [s83f_pkg::EXT_W-1:0]  short_ext_ff, short_ext_in;
   logic                        had_dot_ff, had_dot_in;

   // state after the held byte
   logic [s83f_pkg::BASE_W-1:0] base_upd;
   logic [s83f_pkg::EXT_W-1:0]  ext_upd;
   logic [3:0]                  base_cnt_upd;
   logic [2:0]                  ext_cnt_upd;
   logic [1:0]                  dot_cnt_upd;
   logic                        bad_upd;
   logic [BW-1:0]               byte_up;
   logic                        is_dot;
   logic                        fits;
   logic                        hit;

   logic out_free;
   logic advance;
   logic accept;

   // Advance the held byte when it is non-final, or when the result
   // register is empty or being drained.
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign advance       = hold_valid_ff && (!hold_final_ff || out_free);
   assign req_if.ready  = !hold_valid_ff || advance;
   assign accept        = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   // Fold the held byte into the name state.
   always_comb begin
      byte_up      = s83f_pkg::upcase(hold_byte_ff);
      is_dot       = (hold_byte_ff == s83f_pkg::CHAR_DOT);
      bad_upd      = bad_seen_ff || s83f_pkg::forbidden(hold_byte_ff);
      base_upd     = base_store_ff;
      ext_upd      = ext_store_ff;
      base_cnt_upd = base_count_ff;
      ext_cnt_upd  = ext_count_ff;
      dot_cnt_upd  = dot_count_ff;
      if (is_dot) begin
         if (dot_count_ff != 2'd2) dot_cnt_upd = dot_count_ff + 2'd1;
      end else if (dot_count_ff == 2'd0) begin
         for (int k = 0; k < s83f_pkg::BASE_LEN; k++) begin
            if (base_count_ff == 4'(k)) base_upd[BW*k +: BW] = byte_up;
         end
         if (base_count_ff != 4'd9) base_cnt_upd = base_count_ff + 4'd1;
      end else begin
         for (int k = 0; k < s83f_pkg::EXT_LEN; k++) begin
            if (ext_count_ff == 3'(k)) ext_upd[BW*k +: BW] = byte_up;
         end
         if (ext_count_ff != 3'd4) ext_cnt_upd = ext_count_ff + 3'd1;
      end

      fits = !bad_upd && (dot_cnt_upd <= 2'd1) && (base_cnt_upd != 4'd0) &&
             (base_cnt_upd <= 4'd8) && (ext_cnt_upd <= 3'd3);
      hit  = fits && (match_all_ff ||
             (s83f_pkg::field_match(pat_base_ff, base_upd) &&
              s83f_pkg::field_match(s83f_pkg::BASE_W'(pat_ext_ff),
                                    s83f_pkg::BASE_W'(ext_upd))));
   end

   // Next-state selection for both stages.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      hold_final_in = hold_final_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_byte_in  = req_if.name_byte;
         hold_final_in = req_if.final_byte;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end

      base_store_in = base_store_ff;
      ext_store_in  = ext_store_ff;
      base_count_in = base_count_ff;
      ext_count_in  = ext_count_ff;
      dot_count_in  = dot_count_ff;
      bad_seen_in   = bad_seen_ff;
      if (advance) begin
         if (hold_final_ff) begin
            // drop the name state, ready for the next name
            base_store_in = '0;
            ext_store_in  = '0;
            base_count_in = '0;
            ext_count_in  = '0;
            dot_count_in  = '0;
            bad_seen_in   = 1'b0;
         end else begin
            base_store_in = base_upd;
            ext_store_in  = ext_upd;
            base_count_in = base_cnt_upd;
            ext_count_in  = ext_cnt_upd;
            dot_count_in  = dot_cnt_upd;
            bad_seen_in   = bad_upd;
         end
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      fits_in       = fits_ff;
      hit_in        = hit_ff;
      short_base_in = short_base_ff;
      short_ext_in  = short_ext_ff;
      had_dot_in    = had_dot_ff;
      if (advance && hold_final_ff) begin
         // illegal names report all-zero fields
         rsp_valid_in  = 1'b1;
         fits_in       = fits;
         hit_in        = hit;
         short_base_in = fits ? base_upd : '0;
         short_ext_in  = fits ? ext_upd : '0;
         had_dot_in    = fits && (dot_cnt_upd == 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_base_ff   <= s83f_pkg::BASE_W'(s83f_pkg::CHAR_STAR);
         pat_ext_ff    <= s83f_pkg::EXT_W'(s83f_pkg::CHAR_STAR);
         match_all_ff  <= 1'b1;
         hold_valid_ff <= 1'b0;
         base_store_ff <= '0;
         ext_store_ff  <= '0;
         base_count_ff <= '0;
         ext_count_ff  <= '0;
         dot_count_ff  <= '0;
         bad_seen_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            unique case (csr_if.reg_index)
               s83f_pkg::CSR_PATTERN_BASE:     pat_base_ff  <= csr_if.wdata;
               s83f_pkg::CSR_PATTERN_EXT:      pat_ext_ff   <= csr_if.wdata[s83f_pkg::EXT_W-1:0];
               s83f_pkg::CSR_MATCH_EVERYTHING: match_all_ff <= csr_if.wdata[0];
               default: ;
            endcase
         end
         hold_valid_ff <= hold_valid_in;
         base_store_ff <= base_store_in;
         ext_store_ff  <= ext_store_in;
         base_count_ff <= base_count_in;
         ext_count_ff  <= ext_count_in;
         dot_count_ff  <= dot_count_in;
         bad_seen_ff   <= bad_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      hold_byte_ff  <= hold_byte_in;
      hold_final_ff <= hold_final_in;
      fits_ff       <= fits_in;
      hit_ff        <= hit_in;
      short_base_ff <= short_base_in;
      short_ext_ff  <= short_ext_in;
      had_dot_ff    <= had_dot_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.fits_short_form = fits_ff;
   assign rsp_if.pattern_hit     = hit_ff;
   assign rsp_if.short_base      = short_base_ff;
   assign rsp_if.short_ext       = short_ext_ff;
   assign rsp_if.had_dot         = had_dot_ff;

endmodule

### tb/sv/short_name_83_filter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// short_name_83_filter_core_test
// Streams host file names byte by byte into the 8.3 short-name filter and
// checks each result against a cycle-free predictor of the name state and
// the wildcard match. The pattern registers change between phases. Both
// handshakes idle at random, and once the result side holds off long enough
// to stall the name bytes.
// ----------------------------------------------------------------------------
module short_name_83_filter_core_test;
   import s83f_pkg::*;

   // timing and size of the run
   localparam int unsigned NUM_PHASES   = 16;
   localparam int unsigned PHASE_BYTES  = 78;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned SHOW_LIMIT   = 10;
   localparam int unsigned PRESSURE_PH  = 6;
   localparam int unsigned CALM_PH      = 4;

   // index that no register answers to
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // punctuation that may not appear in a short name
   localparam string RESERVED_PUNCT = "\"*+,/:;<=>?[\\]|";

   typedef enum int unsigned {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] code;
      logic              last;
   } name_beat_type;

   typedef struct packed {
      logic              fits;
      logic              hit;
      logic [BASE_W-1:0] base;
      logic [EXT_W-1:0]  ext;
      logic              dot;
   } short_form_type;

   logic clock;
   logic reset;

   s83f_req_if req_bus();
   s83f_rsp_if rsp_bus();
   s83f_csr_if csr_bus();

   short_name_83_filter_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // queues between stimulus, driver, predictor and monitor
   name_beat_type  name_bytes_pending[$];
   short_form_type awaited_forms[$];
   logic [7:0]     name_buf[$];

   // predictor copy of the name state and of the pattern registers
   logic [BASE_W-1:0] base_acc;
   logic [EXT_W-1:0]  ext_acc;
   logic [3:0]        base_chars;
   logic [2:0]        ext_len;
   logic [1:0]        dot_seen;
   logic              tainted;
   logic [BASE_W-1:0] cfg_pat_base;
   logic [EXT_W-1:0]  cfg_pat_ext;
   logic              cfg_match_all;

   // handshake pacing
   idle_mode_type tx_mode;
   idle_mode_type rx_mode;
   int unsigned   tx_gap;
   int unsigned   rx_gap;
   logic          hold_kick;
   logic          hold_spent;
   int unsigned   rx_hold_left;

   int unsigned fault_count;
   int unsigned faults_shown;

   // ------------------------------------------------------------------------
   // Character helpers
   // ------------------------------------------------------------------------
   function automatic logic [7:0] fold_upper(logic [7:0] c);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         return c & ~CASE_DIFF;
      end
      return c;
   endfunction

   function automatic logic [7:0] fold_lower(logic [7:0] c);
      if (c >= (CHAR_LOW_A - CASE_DIFF) && c <= (CHAR_LOW_Z - CASE_DIFF)) begin
         return c | CASE_DIFF;
      end
      return c;
   endfunction

   function automatic logic reserved_char(logic [7:0] c);
      logic bad;
      bad = (c <= CHAR_SPACE) || (c >= CHAR_DEL);
      for (int k = 0; k < RESERVED_PUNCT.len(); k++) begin
         if (RESERVED_PUNCT[k] == c) bad = 1'b1;
      end
      return bad;
   endfunction

   // any printable byte that is allowed in a name part (never the dot)
   function automatic logic [7:0] legal_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(8'h21, 8'h7E));
      end while (reserved_char(c) || c == CHAR_DOT);
      return c;
   endfunction

   function automatic logic [7:0] bad_char();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(0, CHAR_SPACE));
         1:       return 8'($urandom_range(CHAR_DEL, 8'hFF));
         default: return RESERVED_PUNCT[$urandom_range(0, RESERVED_PUNCT.len() - 1)];
      endcase
   endfunction

   function automatic int unsigned draw_wait(idle_mode_type mode);
      case (mode)
         IDLE_NONE:  return 0;
         IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
         default:    return $urandom_range(0, 9);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   // Walk pattern and name in their own positions: '?' only moves the name
   // position when a name character is left, '*' accepts the rest.
   function automatic logic wild_field_hit(logic [63:0] pat, logic [63:0] nm,
                                           int unsigned lanes);
      int unsigned pi;
      int unsigned si;
      logic [7:0]  p;
      logic [7:0]  ch;
      pi = 0;
      si = 0;
      for (int i = 0; i < lanes; i++) begin
         p  = (pi < lanes) ? pat[pi*8 +: 8] : CHAR_NUL;
         ch = (si < lanes) ? nm[si*8 +: 8] : CHAR_NUL;
         if (p == CHAR_STAR) return 1'b1;
         if (p == CHAR_QMARK) begin
            if (ch != CHAR_NUL) si++;
            pi++;
            continue;
         end
         if (p == CHAR_NUL && ch == CHAR_NUL) return 1'b1;
         if (fold_upper(p) != fold_upper(ch)) return 1'b0;
         pi++;
         si++;
      end
      return 1'b1;
   endfunction

   function automatic void clear_name_state();
      base_acc   = '0;
      ext_acc    = '0;
      base_chars = '0;
      ext_len    = '0;
      dot_seen   = '0;
      tainted    = 1'b0;
   endfunction

   // Fold one accepted name byte into the name state; on the last byte
   // queue the short form that the block has to return.
   function automatic void absorb_name_byte(logic [7:0] c, logic last);
      short_form_type form;
      logic           legal;
      if (reserved_char(c)) tainted = 1'b1;
      if (c == CHAR_DOT) begin
         if (dot_seen < 2) dot_seen++;
      end else if (dot_seen == 0) begin
         if (base_chars < BASE_LEN) base_acc[base_chars*8 +: 8] = fold_upper(c);
         if (base_chars < BASE_LEN + 1) base_chars++;
      end else begin
         if (ext_len < EXT_LEN) ext_acc[ext_len*8 +: 8] = fold_upper(c);
         if (ext_len < EXT_LEN + 1) ext_len++;
      end
      if (!last) return;
      legal = !tainted && dot_seen <= 1 && base_chars >= 1 && base_chars <= BASE_LEN &&
              ext_len <= EXT_LEN;
      form = '0;
      if (legal) begin
         form.fits = 1'b1;
         form.hit  = cfg_match_all ||
                     (wild_field_hit(cfg_pat_base, base_acc, BASE_LEN) &&
                      wild_field_hit({40'b0, cfg_pat_ext}, {40'b0, ext_acc}, EXT_LEN));
         form.base = base_acc;
         form.ext  = ext_acc;
         form.dot  = (dot_seen == 1);
      end
      awaited_forms.push_back(form);
      clear_name_state();
   endfunction

   function automatic string form_text(short_form_type f);
      return $sformatf("fits=%0b hit=%0b base=%h ext=%h dot=%0b",
                       f.fits, f.hit, f.base, f.ext, f.dot);
   endfunction

   function automatic void log_fault(string what, short_form_type want, short_form_type got);
      fault_count++;
      if (faults_shown < SHOW_LIMIT) begin
         faults_shown++;
         $display("%s: expected %s, got %s", what, form_text(want), form_text(got));
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock, and every input held at a known value from time zero
   // ------------------------------------------------------------------------
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.name_byte  = '0;
      req_bus.final_byte = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.reg_index  = '0;
      csr_bus.wdata      = '0;
      hold_kick          = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Name byte driver: predict on each accepted transaction, hold the
   // offered byte while it is refused, then idle or offer the next one.
   // Only one assignment to valid per edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_name_byte(req_bus.name_byte, req_bus.final_byte);
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold: the block has not taken this byte yet
         end else if (tx_gap != 0) begin
            tx_gap--;
            req_bus.valid <= 1'b0;
         end else if (name_bytes_pending.size() != 0) begin
            req_bus.name_byte  <= name_bytes_pending[0].code;
            req_bus.final_byte <= name_bytes_pending[0].last;
            req_bus.valid      <= 1'b1;
            void'(name_bytes_pending.pop_front());
            tx_gap = draw_wait(tx_mode);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Long hold-off of the result side, counted here so that the sender keeps
   // offering bytes and the block backs up into its input.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rx_hold_left <= 0;
         hold_spent   <= 1'b0;
      end else if (hold_kick && !hold_spent) begin
         rx_hold_left <= LONG_HOLD;
         hold_spent   <= 1'b1;
      end else if (rx_hold_left != 0) begin
         rx_hold_left <= rx_hold_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: compare each accepted transaction with the oldest
   // awaited short form, then pace ready.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      short_form_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.fits = rsp_bus.fits_short_form;
            got.hit  = rsp_bus.pattern_hit;
            got.base = rsp_bus.short_base;
            got.ext  = rsp_bus.short_ext;
            got.dot  = rsp_bus.had_dot;
            if (awaited_forms.size() == 0) begin
               log_fault("result with nothing awaited", '0, got);
            end else begin
               if (got.fits !== awaited_forms[0].fits || got.hit !== awaited_forms[0].hit ||
                   got.base !== awaited_forms[0].base || got.ext !== awaited_forms[0].ext ||
                   got.dot !== awaited_forms[0].dot) begin
                  log_fault("short form mismatch", awaited_forms[0], got);
               end
               void'(awaited_forms.pop_front());
            end
            rx_gap = draw_wait(rx_mode);
         end
         if (rx_hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (rx_gap != 0) begin
            rx_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: give up when no channel moves a transaction for too long
   // ------------------------------------------------------------------------
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("short_name_83_filter_core verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Write one register and update the predictor's copy on its transaction.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_PATTERN_BASE:     cfg_pat_base  = value;
         CSR_PATTERN_EXT:      cfg_pat_ext   = value[EXT_W-1:0];
         CSR_MATCH_EVERYTHING: cfg_match_all = value[0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   // Move the built name to the driver, marking its last byte.
   task automatic push_name();
      name_beat_type beat;
      foreach (name_buf[k]) begin
         beat.code = name_buf[k];
         beat.last = (k == name_buf.size() - 1);
         name_bytes_pending.push_back(beat);
      end
      name_buf.delete();
   endtask

   task automatic push_text(string s);
      for (int k = 0; k < s.len(); k++) name_buf.push_back(s[k]);
      push_name();
   endtask

   task automatic add_legal(int unsigned n);
      repeat (n) name_buf.push_back(legal_char());
   endtask

   // Wait until every byte is taken and every result has come back, then
   // let the pipeline drain before anything is reconfigured.
   task automatic settle();
      while (name_bytes_pending.size() != 0 || req_bus.valid || awaited_forms.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Turn a stem into a pattern: keep, lower-case, '?', '*' or a random legal character each lane.
   function automatic logic [63:0] wildcard_from(logic [63:0] src, int unsigned len,
                                                 int unsigned lanes);
      logic [63:0] pat;
      int unsigned at;
      int unsigned r;
      logic [7:0]  c;
      pat = '0;
      at  = 0;
      for (int k = 0; k < len; k++) begin
         r = $urandom_range(0, 99);
         c = src[k*8 +: 8];
         if (r < 70) begin
            pat[at*8 +: 8] = (r < 25) ? fold_lower(c) : c;
         end else if (r < 85) begin
            pat[at*8 +: 8] = CHAR_QMARK;
         end else if (r < 92) begin
            pat[at*8 +: 8] = CHAR_STAR;
            return pat;
         end else begin
            pat[at*8 +: 8] = legal_char();
         end
         at++;
      end
      if (at < lanes && $urandom_range(0, 4) == 0) begin
         pat[at*8 +: 8] = $urandom_range(0, 1) ? CHAR_STAR : CHAR_QMARK;
      end
      return pat;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic [63:0]  stem_base;
      logic [23:0]  stem_ext;
      int unsigned  stem_base_len;
      int unsigned  stem_ext_len;
      logic         stem_dot;
      logic [63:0]  pb;
      logic [23:0]  pe;
      logic         me;
      int unsigned  pushed;
      int unsigned  kind;
      int unsigned  r;
      logic [7:0]   c;

      fault_count   = 0;
      faults_shown  = 0;
      tx_mode       = IDLE_LIGHT;
      rx_mode       = IDLE_LIGHT;
      cfg_pat_base  = BASE_W'(CHAR_STAR);
      cfg_pat_ext   = EXT_W'(CHAR_STAR);
      cfg_match_all = 1'b1;
      clear_name_state();

      // one reset at the start, never again
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed names under the reset pattern
      push_text("a");             // single lower-case letter
      push_text(".");             // empty base
      push_text("..");            // two dots
      push_text("Q.");            // trailing dot, empty extension
      name_buf.push_back(8'h00);  // lowest byte value
      push_name();
      name_buf.push_back(8'hFF);  // highest byte value
      push_name();
      push_text("x*");            // reserved punctuation
      push_text("ABCDEFGH.xyz");  // longest legal name
      settle();

      for (int unsigned phase = 1; phase <= NUM_PHASES; phase++) begin
         // fresh stem for this phase; many names and often the pattern come from it
         stem_base     = '0;
         stem_ext      = '0;
         stem_base_len = $urandom_range(1, BASE_LEN);
         stem_ext_len  = $urandom_range(0, EXT_LEN);
         stem_dot      = (stem_ext_len != 0) || ($urandom_range(0, 3) == 0);
         for (int k = 0; k < stem_base_len; k++) stem_base[k*8 +: 8] = fold_upper(legal_char());
         for (int k = 0; k < stem_ext_len; k++) stem_ext[k*8 +: 8] = fold_upper(legal_char());

         case (phase)
            1: begin
               pb = '0;
               pe = '0;
               me = 1'b0;
            end
            2: begin
               pb = '1;
               pe = '1;
               me = 1'b1;
            end
            3: begin
               pb = '1;
               pe = '1;
               me = 1'b0;
            end
            CALM_PH: begin
               pb = 64'(CHAR_STAR);
               pe = '0;
               me = 1'b0;
            end
            default: begin
               r = $urandom_range(0, 99);
               if (r < 15) begin
                  pb = {$urandom, $urandom};
                  pe = 24'($urandom);
                  me = 1'($urandom_range(0, 1));
               end else begin
                  pb = wildcard_from(stem_base, stem_base_len, BASE_LEN);
                  pe = 24'(wildcard_from({40'b0, stem_ext}, stem_ext_len, EXT_LEN));
                  me = (r < 30);
               end
            end
         endcase
         write_register(CSR_PATTERN_BASE, pb);
         write_register(CSR_PATTERN_EXT, {$urandom, 8'($urandom), pe});
         write_register(CSR_MATCH_EVERYTHING, {$urandom, 31'($urandom), me});
         if (phase == 2) write_register(CSR_UNMAPPED, {$urandom, $urandom});

         // pacing: one phase without any idling, one with the long hold-off
         if (phase == CALM_PH) begin
            tx_mode = IDLE_NONE;
            rx_mode = IDLE_NONE;
         end else if (phase == PRESSURE_PH) begin
            tx_mode = IDLE_NONE;
            rx_mode = idle_mode_type'($urandom_range(0, 2));
            hold_kick <= 1'b1;
         end else begin
            tx_mode = idle_mode_type'($urandom_range(0, 2));
            rx_mode = idle_mode_type'($urandom_range(0, 2));
         end

         pushed = 0;
         while (pushed < PHASE_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
               // variant of the stem: drop, swap or lower-case a few characters
               for (int k = 0; k < stem_base_len; k++) begin
                  r = $urandom_range(0, 99);
                  c = stem_base[k*8 +: 8];
                  if (r < 10) name_buf.push_back(legal_char());
                  else if (r >= 14) name_buf.push_back(r < 40 ? fold_lower(c) : c);
               end
               if ($urandom_range(0, 9) == 0) add_legal(1);
               if (name_buf.size() == 0) add_legal(1);
               if (stem_dot ^ ($urandom_range(0, 9) == 0)) begin
                  name_buf.push_back(CHAR_DOT);
                  for (int k = 0; k < stem_ext_len; k++) begin
                     r = $urandom_range(0, 99);
                     c = stem_ext[k*8 +: 8];
                     if (r < 10) name_buf.push_back(legal_char());
                     else if (r >= 14) name_buf.push_back(r < 40 ? fold_lower(c) : c);
                  end
                  if ($urandom_range(0, 9) == 0) add_legal(1);
               end
            end else if (kind < 55) begin
               // well-formed name with random content
               add_legal($urandom_range(1, BASE_LEN));
               if ($urandom_range(0, 9) < 7) begin
                  name_buf.push_back(CHAR_DOT);
                  add_legal($urandom_range(0, EXT_LEN));
               end
            end else if (kind < 67) begin
               // base too long, past the saturation point too
               add_legal($urandom_range(BASE_LEN + 1, 20));
               if ($urandom_range(0, 1)) begin
                  name_buf.push_back(CHAR_DOT);
                  add_legal($urandom_range(0, EXT_LEN));
               end
            end else if (kind < 77) begin
               // extension too long
               add_legal($urandom_range(1, BASE_LEN));
               name_buf.push_back(CHAR_DOT);
               add_legal($urandom_range(EXT_LEN + 1, 10));
            end else if (kind < 85) begin
               // dots scattered anywhere, leading ones included
               repeat ($urandom_range(1, 10)) begin
                  if ($urandom_range(0, 99) < 35) name_buf.push_back(CHAR_DOT);
                  else name_buf.push_back(legal_char());
               end
            end else if (kind < 93) begin
               // legal shape spoiled by one forbidden byte
               add_legal($urandom_range(1, BASE_LEN));
               if ($urandom_range(0, 1)) begin
                  name_buf.push_back(CHAR_DOT);
                  add_legal($urandom_range(0, EXT_LEN));
               end
               name_buf[$urandom_range(0, name_buf.size() - 1)] = bad_char();
            end else begin
               // raw noise over the whole byte range
               repeat ($urandom_range(1, 12)) name_buf.push_back(8'($urandom_range(0, 255)));
            end
            pushed += name_buf.size();
            push_name();
         end
         settle();
      end

      if (fault_count == 0) begin
         $display("short_name_83_filter_core verification clean");
      end else begin
         $display("short_name_83_filter_core verification failed");
      end
      $finish;
   end

endmodule
